@@ src/cvde_pkg.sv @@
// Shared constants for the value dictionary encoder.
// Used by csrv_value_dictionary_encoder and by the testbench.
package cvde_pkg;

	localparam int DICT_DEPTH  = 256;
	localparam int MAX_COLUMNS = 1024;

	localparam int VAL_W  = 64;
	localparam int COL_W  = 11;
	localparam int CODE_W = 19;
	localparam int STAT_W = 2;
	localparam int IDX_W  = $clog2(DICT_DEPTH);
	localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
	localparam int PROD_W = IDX_W + COL_W;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_DICT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_COL_OVER = 2'd2;

	// columns per row after clamping to 1 .. MAX_COLUMNS
	function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] c);
		logic [COL_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = COL_W'(1);
		end else if (32'(c) > MAX_COLUMNS) begin
			r = COL_W'(MAX_COLUMNS);
		end
		return r;
	endfunction

endpackage

@@ src/cvde_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvde_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/csrv_value_dictionary_encoder.sv @@
// Top level of the sparse matrix value dictionary encoder.
// Depends on cvde_pkg and cvde_ram (dictionary storage).
//
//  channel   handshake                    payload
//  cell in   start / busy                 value_bits, last_in_row, first_of_block
//  config    cfg_valid / cfg_ready        cfg_data (num_columns)
//  result    result_valid (strobe)        code, is_new_value, new_value_bits,
//                                         status, last
//
// A cell that is zero or past the row width skips the dictionary. Otherwise the
// dictionary is scanned one entry per cycle through the RAM read port; a hit
// or a new entry then passes S_MUL and S_CODE, while a miss on a full dictionary
// reports ST_DICT_FULL. Results are one-cycle strobes; the receiver cannot
// stall. Reset clears the entry count, column counter and num_columns (to 1);
// dictionary contents need no clearing since only entries below the count are read.
module csrv_value_dictionary_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [cvde_pkg::VAL_W-1:0] value_bits,
	input  logic                       last_in_row,
	input  logic                       first_of_block,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cvde_pkg::COL_W-1:0] cfg_data,
	output logic                       result_valid,
	output logic [cvde_pkg::CODE_W-1:0] code,
	output logic                       is_new_value,
	output logic [cvde_pkg::VAL_W-1:0] new_value_bits,
	output logic [cvde_pkg::STAT_W-1:0] status,
	output logic                       last
);

	localparam int IDX_W  = cvde_pkg::IDX_W;
	localparam int CNT_W  = cvde_pkg::CNT_W;
	localparam int COL_W  = cvde_pkg::COL_W;
	localparam int PROD_W = cvde_pkg::PROD_W;
	localparam int CODE_W = cvde_pkg::CODE_W;
	localparam int VAL_W  = cvde_pkg::VAL_W;
	localparam int STAT_W = cvde_pkg::STAT_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MISS  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_CODE  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]        state_q;
	logic [COL_W-1:0]  ncols_q;
	logic [CNT_W-1:0]  count_q;
	logic [COL_W-1:0]  col_q;
	logic [IDX_W-1:0]  idx_q;
	logic              is_new_q;
	logic [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]  val_q;
	logic              row_end_q;

	logic              res_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              is_new_out_q;
	logic [VAL_W-1:0]  nv_out_q;
	logic [STAT_W-1:0] stat_q;
	logic              last_q;

	logic [COL_W-1:0]  cols;
	logic              val_zero;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic [PROD_W:0]   code_sum;
	logic              scan_end;
	logic              dict_full;
	logic              res_emit;

	assign cols      = cvde_pkg::eff_cols(ncols_q);
	assign val_zero  = (val_q[VAL_W-2:0] == '0);
	assign ram_we    = (state_q == S_MISS) && !dict_full;
	assign ram_raddr = (state_q == S_CHECK) ? '0 : IDX_W'(idx_q + 1'b1);
	assign code_sum  = {1'b0, prod_q} + (PROD_W+1)'(col_q) + (PROD_W+1)'(1);
	assign scan_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign dict_full = (count_q == CNT_W'(cvde_pkg::DICT_DEPTH));

	// states that put a word on the result ports next cycle
	assign res_emit  = ((state_q == S_CHECK) && !val_zero && (col_q >= cols))
		|| ((state_q == S_MISS) && dict_full)
		|| (state_q == S_CODE)
		|| ((state_q == S_FIN) && row_end_q);

	cvde_ram #(
		.WIDTH(VAL_W),
		.DEPTH(cvde_pkg::DICT_DEPTH)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(val_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ncols_q     <= COL_W'(1);
			count_q     <= '0;
			col_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_emit;
			if (cfg_valid) begin
				ncols_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q     <= value_bits;
						row_end_q <= last_in_row;
						if (first_of_block) begin
							count_q <= '0;
							col_q   <= '0;
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					idx_q    <= '0;
					is_new_q <= 1'b0;
					if (val_zero) begin
						state_q <= S_FIN;
					end else if (col_q >= cols) begin
						code_q       <= '0;
						is_new_out_q <= 1'b0;
						nv_out_q     <= '0;
						stat_q       <= cvde_pkg::ST_COL_OVER;
						last_q       <= !row_end_q;
						state_q      <= S_FIN;
					end else if (count_q == '0) begin
						state_q <= S_MISS;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read word for idx_q lands this cycle
					if (ram_rdata == val_q) begin
						state_q <= S_MUL;
					end else if (scan_end) begin
						state_q <= S_MISS;
					end else begin
						idx_q <= IDX_W'(idx_q + 1'b1);
					end
				end
				S_MISS: begin
					if (dict_full) begin
						code_q       <= '0;
						is_new_out_q <= 1'b0;
						nv_out_q     <= '0;
						stat_q       <= cvde_pkg::ST_DICT_FULL;
						last_q       <= !row_end_q;
						state_q      <= S_FIN;
					end else begin
						idx_q    <= count_q[IDX_W-1:0];
						is_new_q <= 1'b1;
						count_q  <= CNT_W'(count_q + 1'b1);
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(idx_q) * PROD_W'(cols);
					state_q <= S_CODE;
				end
				S_CODE: begin
					code_q       <= code_sum[CODE_W-1:0];
					is_new_out_q <= is_new_q;
					nv_out_q     <= is_new_q ? val_q : '0;
					stat_q       <= cvde_pkg::ST_OK;
					last_q       <= !row_end_q;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					if (row_end_q) begin
						code_q       <= '0;
						is_new_out_q <= 1'b0;
						nv_out_q     <= '0;
						stat_q       <= cvde_pkg::ST_OK;
						last_q       <= 1'b1;
						col_q        <= '0;
					end else if (32'(col_q) < cvde_pkg::MAX_COLUMNS) begin
						col_q <= COL_W'(col_q + 1'b1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign result_valid   = res_valid_q;
	assign code           = code_q;
	assign is_new_value   = is_new_out_q;
	assign new_value_bits = nv_out_q;
	assign status         = stat_q;
	assign last           = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(cvde_pkg::DICT_DEPTH))
		else $error("entry count past dictionary depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q))
		else $error("scan index past entry count");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != cvde_pkg::ST_OK) |-> (code == '0 && !is_new_value))
		else $error("error word carries a code");

	a_new_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !is_new_value) |-> (new_value_bits == '0))
		else $error("value bits on a word that adds nothing");

	a_col_over: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (col_q < cols))
		else $error("encoding a column past the row width");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for csrv_value_dictionary_encoder.
// Needs cvde_pkg and the encoder RTL. Keeps its own dictionary model, queues the expected
// result words per cell and checks every strobed word in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VAL_W       = cvde_pkg::VAL_W;
	localparam int COL_W       = cvde_pkg::COL_W;
	localparam int CODE_W      = cvde_pkg::CODE_W;
	localparam int STAT_W      = cvde_pkg::STAT_W;
	localparam int DICT_DEPTH  = cvde_pkg::DICT_DEPTH;
	localparam int MAX_COLUMNS = cvde_pkg::MAX_COLUMNS;

	localparam logic [STAT_W-1:0] ST_DICT_FULL = cvde_pkg::ST_DICT_FULL;
	localparam logic [STAT_W-1:0] ST_COL_OVER  = cvde_pkg::ST_COL_OVER;

	localparam int WATCHDOG_LIMIT = 4000;
	// longest item: a hit on the last entry or a miss that adds the last entry
	localparam int SETTLE_CYCLES  = 270;

	localparam logic [VAL_W-1:0] POS_ZERO  = 64'h0000_0000_0000_0000;
	localparam logic [VAL_W-1:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
	localparam logic [VAL_W-1:0] ONE_POS   = 64'h3FF0_0000_0000_0000;
	localparam logic [VAL_W-1:0] ONE_NEG   = 64'hBFF0_0000_0000_0000;
	localparam logic [VAL_W-1:0] FILL_BASE = 64'h4000_0000_0000_0000;
	localparam logic [VAL_W-1:0] FILL_MISS = 64'hC000_0000_0000_0000;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              is_new;
		logic [VAL_W-1:0]  nv;
		logic [STAT_W-1:0] st;
		logic              lst;
	} enc_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VAL_W-1:0]   value_bits;
	logic               last_in_row;
	logic               first_of_block;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COL_W-1:0]   cfg_data;
	logic               result_valid;
	logic [CODE_W-1:0]  code;
	logic               is_new_value;
	logic [VAL_W-1:0]   new_value_bits;
	logic [STAT_W-1:0]  status;
	logic               last;

	// encoder model state
	logic [VAL_W-1:0]   dict_vals [DICT_DEPTH];
	int                 dict_cnt = 0;
	int                 col_pos = 0;
	logic [COL_W-1:0]   cols_reg = 11'd1;

	enc_word_t          pending_words [$];
	logic [VAL_W-1:0]   block_pool [$];
	int                 mismatch_cnt = 0;
	int                 idle_cycles = 0;

	csrv_value_dictionary_encoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value_bits     (value_bits),
		.last_in_row    (last_in_row),
		.first_of_block (first_of_block),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.code           (code),
		.is_new_value   (is_new_value),
		.new_value_bits (new_value_bits),
		.status         (status),
		.last           (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int clamped_cols();
		if (cols_reg == '0) begin
			return 1;
		end
		if (int'(cols_reg) > MAX_COLUMNS) begin
			return MAX_COLUMNS;
		end
		return int'(cols_reg);
	endfunction

	// queue the words one accepted cell produces and advance the model
	task automatic encode_cell(input logic [VAL_W-1:0] v, input bit row_end, input bit fob);
		enc_word_t w;
		int        cols;
		int        idx;
		int        i;
		bit        hit;
		if (fob) begin
			dict_cnt = 0;
			col_pos  = 0;
		end
		cols = clamped_cols();
		if (v[VAL_W-2:0] != '0) begin
			w     = '0;
			w.lst = !row_end;
			if (col_pos >= cols) begin
				w.st = ST_COL_OVER;
			end else begin
				hit = 1'b0;
				idx = 0;
				for (i = 0; i < dict_cnt && !hit; i++) begin
					if (dict_vals[i] == v) begin
						idx = i;
						hit = 1'b1;
					end
				end
				if (hit) begin
					w.code = CODE_W'(1 + idx * cols + col_pos);
				end else if (dict_cnt >= DICT_DEPTH) begin
					w.st = ST_DICT_FULL;
				end else begin
					dict_vals[dict_cnt] = v;
					w.code   = CODE_W'(1 + dict_cnt * cols + col_pos);
					w.is_new = 1'b1;
					w.nv     = v;
					dict_cnt++;
				end
			end
			pending_words.insert(pending_words.size(), w);
		end
		if (col_pos < MAX_COLUMNS) begin
			col_pos++;
		end
		if (row_end) begin
			w     = '0;
			w.lst = 1'b1;
			pending_words.insert(pending_words.size(), w);
			col_pos = 0;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		mismatch_cnt++;
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	// result word checker
	always @(posedge clk) begin
		enc_word_t w;
		if (arst_n && result_valid) begin
			if (pending_words.size() == 0) begin
				flag_mismatch("unexpected word", VAL_W'(code), '0);
			end else begin
				w = pending_words.pop_front();
				if (code !== w.code) flag_mismatch("code", VAL_W'(code), VAL_W'(w.code));
				if (is_new_value !== w.is_new)
					flag_mismatch("is_new_value", VAL_W'(is_new_value), VAL_W'(w.is_new));
				if (new_value_bits !== w.nv)
					flag_mismatch("new_value_bits", new_value_bits, w.nv);
				if (status !== w.st) flag_mismatch("status", VAL_W'(status), VAL_W'(w.st));
				if (last !== w.lst) flag_mismatch("last", VAL_W'(last), VAL_W'(w.lst));
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// start stays high on return so back-to-back cells need no extra edge
	task automatic push_cell(input logic [VAL_W-1:0] v, input bit row_end, input bit fob);
		@(negedge clk);
		start          <= 1'b1;
		value_bits     <= v;
		last_in_row    <= row_end;
		first_of_block <= fob;
		@(posedge clk);
		while (busy) @(posedge clk);
		encode_cell(v, row_end, fob);
	endtask

	task automatic hold_off(input int n);
		@(negedge clk);
		start          <= 1'b0;
		value_bits     <= {$urandom, $urandom};
		last_in_row    <= 1'($urandom_range(0, 1));
		first_of_block <= 1'($urandom_range(0, 1));
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 95) begin
			hold_off($urandom_range(8, 40));
		end else if (r >= 70) begin
			hold_off($urandom_range(1, 3));
		end
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// zero cells give no word, so let any cell still in flight finish first
	task automatic set_columns(input logic [COL_W-1:0] v);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cols_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= 11'($urandom);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int               r;
		logic [VAL_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			v = {1'($urandom_range(0, 1)), 63'd0};
		end else if (r < 70 && block_pool.size() > 0) begin
			v = block_pool[$urandom_range(0, block_pool.size() - 1)];
		end else begin
			v = {$urandom, $urandom};
			block_pool.insert(block_pool.size(), v);
		end
		return v;
	endfunction

	// reset value of num_columns is 1
	task automatic test_reset_columns();
		push_cell(ONE_POS, 1'b0, 1'b0);
		push_cell(FILL_BASE, 1'b0, 1'b0);
		push_cell(POS_ZERO, 1'b1, 1'b0);
	endtask

	task automatic test_directed_cells();
		set_columns(11'd4);
		push_cell(POS_ZERO, 1'b0, 1'b1);
		push_cell(NEG_ZERO, 1'b0, 1'b0);
		push_cell(ONE_POS, 1'b0, 1'b0);
		push_cell(ONE_POS, 1'b1, 1'b0);
		hold_off(2);
		push_cell(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
		push_cell(64'h0000_0000_0000_0001, 1'b0, 1'b0);
		push_cell(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
		push_cell(64'h8000_0000_0000_0001, 1'b0, 1'b0);
		// past the row width: known and unseen values both rejected
		push_cell(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
		push_cell(64'h0000_0000_0000_1234, 1'b1, 1'b0);
		push_cell(ONE_NEG, 1'b1, 1'b1);
		push_cell(NEG_ZERO, 1'b1, 1'b0);
		push_cell(POS_ZERO, 1'b1, 1'b1);
		// zero columns act as one
		set_columns(11'd0);
		push_cell(ONE_POS, 1'b0, 1'b1);
		push_cell(ONE_NEG, 1'b0, 1'b0);
		push_cell(POS_ZERO, 1'b1, 1'b0);
	endtask

	task automatic test_dictionary_full();
		int i;
		set_columns(11'd2047);
		for (i = 0; i < DICT_DEPTH; i++) begin
			push_cell(FILL_BASE | VAL_W'(i), 1'b0, i == 0);
		end
		push_cell(FILL_MISS, 1'b0, 1'b0);
		for (i = DICT_DEPTH + 1; i < MAX_COLUMNS - 1; i++) begin
			push_cell(POS_ZERO, 1'b0, 1'b0);
		end
		// last entry in the last column: top code value
		push_cell(FILL_BASE | VAL_W'(DICT_DEPTH - 1), 1'b0, 1'b0);
		// column counter runs past the clamped width and saturates
		for (i = 0; i < 6; i++) begin
			push_cell(FILL_BASE, 1'b0, 1'b0);
		end
		push_cell(POS_ZERO, 1'b1, 1'b0);
		push_cell(FILL_BASE, 1'b0, 1'b0);
		push_cell(FILL_MISS, 1'b1, 1'b0);
		set_columns(11'd1024);
		push_cell(FILL_MISS, 1'b0, 1'b1);
		push_cell(FILL_BASE, 1'b1, 1'b0);
	endtask

	// rows match the configured width up to 20 cells, else take 1 to 20; some overrun or stop short
	task automatic random_phase(input int n_items);
		int sent;
		int eff;
		int row_len;
		int k;
		bit burst;
		bit new_block;
		bit fob;
		sent      = 0;
		new_block = 1'b1;
		while (sent < n_items) begin
			eff     = clamped_cols();
			row_len = (eff <= 20) ? eff : $urandom_range(1, 20);
			if ($urandom_range(0, 9) == 0) begin
				row_len += $urandom_range(1, 3);
			end else if ($urandom_range(0, 9) == 0) begin
				row_len = $urandom_range(1, row_len);
			end
			burst = ($urandom_range(0, 3) == 0);
			for (k = 0; k < row_len; k++) begin
				fob = (k == 0 && new_block) || ($urandom_range(0, 49) == 0);
				if (fob) begin
					block_pool.delete();
				end
				push_cell(pick_value(), k == row_len - 1, fob);
				sent++;
				if (!burst) begin
					random_gap();
				end
			end
			new_block = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0) begin
				wait_results_done();
			end
		end
	endtask

	task automatic test_random_blocks();
		random_phase(135);
		set_columns(11'd3);
		random_phase(135);
		set_columns(11'd0);
		random_phase(135);
		set_columns(11'd1024);
		random_phase(135);
		set_columns(11'($urandom_range(2, 40)));
		random_phase(135);
		set_columns(11'd2047);
		random_phase(135);
		set_columns(11'd1);
		random_phase(135);
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		value_bits     = '0;
		last_in_row    = 1'b0;
		first_of_block = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_columns();
		test_directed_cells();
		test_dictionary_full();
		test_random_blocks();

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/cvde_pkg.sv
src/cvde_ram.sv
src/csrv_value_dictionary_encoder.sv
dv/tb_top.sv
